// ===== design/imukf_pkg.sv =====
// Package for the accelerometer Kalman filter: widths, register indexes and
// reset constants shared by the top level and the serial divider.
// No dependencies.
`timescale 1ns / 1ps

package imukf_pkg;

  // Field and arithmetic widths
  localparam int unsigned AXIS_W  = 16;  // one accelerometer axis
  localparam int unsigned DIFF_W  = 17;  // z - prev
  localparam int unsigned COV_W   = 24;  // Q8.16 covariance and noise terms
  localparam int unsigned DEN_W   = 25;  // Pp + R
  localparam int unsigned REM_W   = 26;  // divider partial remainder
  localparam int unsigned GAIN_W  = 17;  // Q1.16 gain, 0 .. 1.0
  localparam int unsigned PROD_W  = 34;  // gain * diff, signed
  localparam int unsigned CPROD_W = 41;  // (1 - gain) * Pp, unsigned
  localparam int unsigned DATA_W  = 48;  // three packed axes
  localparam int unsigned IDX_W   = 2;   // configuration register index
  localparam int unsigned CNT_W   = 5;   // serial step counter

  // One quotient or multiplier bit per cycle
  localparam logic [CNT_W-1:0] SERIAL_STEPS = 5'd17;

  localparam logic [GAIN_W-1:0] FRAC_ONE = 17'h10000;
  localparam logic [COV_W-1:0]  COV_MAX  = 24'hFFFFFF;

  // Register reset values
  localparam logic [COV_W-1:0] Q_RESET   = 24'd1966;
  localparam logic [COV_W-1:0] R_RESET   = 24'd239206;
  localparam logic [COV_W-1:0] COV_RESET = 24'd65536;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

// ===== design/imukf_div.sv =====
// Radix-2 restoring divider for the Kalman gain: quo = floor(num * 2^16 / den)
// for num <= den, one quotient bit per cycle. Depends on imukf_pkg.
`timescale 1ns / 1ps

module imukf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [imukf_pkg::COV_W-1:0]   num_i,
  input  logic [imukf_pkg::DEN_W-1:0]   den_i,
  output logic                          last_o,   // final quotient bit this cycle
  output logic [imukf_pkg::GAIN_W-1:0]  quo_o
);

  logic [imukf_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [imukf_pkg::DEN_W-1:0]  den_q;
  logic [imukf_pkg::GAIN_W-1:0] quo_q, quo_d;
  logic [imukf_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [imukf_pkg::REM_W-1:0]  den_ext;
  logic [imukf_pkg::REM_W-1:0]  diff;
  logic                         ge;

  // One compare and subtract step
  assign den_ext = {{(imukf_pkg::REM_W-imukf_pkg::DEN_W){1'b0}}, den_q};
  assign ge      = (rem_q >= den_ext);
  assign diff    = ge ? (rem_q - den_ext) : rem_q;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = {{(imukf_pkg::REM_W-imukf_pkg::COV_W){1'b0}}, num_i};
      quo_d = '0;
      cnt_d = imukf_pkg::SERIAL_STEPS;
    end else if (cnt_q != '0) begin
      rem_d = {diff[imukf_pkg::REM_W-2:0], 1'b0};
      quo_d = {quo_q[imukf_pkg::GAIN_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Counter is control; datapath registers need no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign last_o = (cnt_q == 5'd1);
  assign quo_o  = quo_q;

endmodule

// ===== design/imu_accel_kalman_filter_top.sv =====
// Channel      | Dir | Handshake              | Payload
// s_axis       | in  | s_axis_tvalid/tready   | tdata: accel_x, accel_y, accel_z
// m_axis       | out | m_axis_tvalid/tready   | tdata: filtered_x, filtered_y, filtered_z
// cfg          | in  | cfg_we_i               | cfg_idx_i, cfg_data_i (Q, R)
//
// A filtering transaction runs the bit-serial gain division (DIV), loads the
// multipliers (MSET), forms the bit-serial products (MUL), then rounds, saturates
// and registers the result (FIN). A new sample is taken only back in IDLE, once the
// previous one has left FIN. The first sample after reset goes straight to FIN.
// Reset restores Q, R, covariance 1.0 and the first-sample flag. A stalled result
// stays in the output register; the next sample waits in FIN.
//
// Depends on imukf_pkg and imukf_div.
`timescale 1ns / 1ps

module imu_accel_kalman_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [imukf_pkg::DATA_W-1:0]   s_axis_tdata,   // accel_x, accel_y, accel_z
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [imukf_pkg::DATA_W-1:0]   m_axis_tdata,   // filtered_x, filtered_y, filtered_z
  // Configuration writes
  input  logic                           cfg_we_i,
  input  logic [imukf_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [imukf_pkg::COV_W-1:0]    cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MSET = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam int unsigned NAX = 3;

  logic [2:0] state_q, state_d;

  // Configuration and filter state
  logic [imukf_pkg::COV_W-1:0] q_noise_q, r_noise_q, cov_q;
  logic                        have_prev_q, first_q;
  imukf_pkg::axis_t            prev_q [NAX];
  imukf_pkg::axis_t            z_q    [NAX];
  imukf_pkg::axis_t            z_in   [NAX];

  // Serial multiplier datapath
  logic [imukf_pkg::GAIN_W-1:0]  mplr_g_q, mplr_c_q;
  imukf_pkg::prod_t              mcand_q [NAX];
  imukf_pkg::prod_t              acc_q   [NAX];
  logic [imukf_pkg::CPROD_W-1:0] mcand_p_q, acc_p_q;
  logic [imukf_pkg::CNT_W-1:0]   cnt_q;
  logic [imukf_pkg::COV_W-1:0]   pp_q;
  logic                          den_zero_q;

  logic [imukf_pkg::AXIS_W-1:0]  out_q [NAX];
  logic                          out_valid_q;

  logic                          s_acc, out_free, fin_go;
  logic [imukf_pkg::DEN_W-1:0]   pp_sum, den;
  logic [imukf_pkg::COV_W-1:0]   pp;
  logic                          div_last;
  logic [imukf_pkg::GAIN_W-1:0]  div_quo, gain;
  logic [imukf_pkg::AXIS_W-1:0]  res [NAX];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fin_go        = (state_q == ST_FIN) && out_free;

  // Unpack the input sample
  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      z_in[k] = s_axis_tdata[k*imukf_pkg::AXIS_W +: imukf_pkg::AXIS_W];
    end
  end

  // Predicted covariance, saturated, and the gain denominator
  assign pp_sum = {1'b0, cov_q} + {1'b0, q_noise_q};
  assign pp     = pp_sum[imukf_pkg::COV_W] ? imukf_pkg::COV_MAX
                                           : pp_sum[imukf_pkg::COV_W-1:0];
  assign den    = {1'b0, pp} + {1'b0, r_noise_q};

  imukf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_acc && have_prev_q),
    .num_i   (pp),
    .den_i   (den),
    .last_o  (div_last),
    .quo_o   (div_quo)
  );

  assign gain = den_zero_q ? '0 : div_quo;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_acc) state_d = have_prev_q ? ST_DIV : ST_FIN;
      ST_DIV:  if (div_last) state_d = ST_MSET;
      ST_MSET: state_d = ST_MUL;
      ST_MUL:  if (cnt_q == 5'd1) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      q_noise_q   <= imukf_pkg::Q_RESET;
      r_noise_q   <= imukf_pkg::R_RESET;
      cov_q       <= imukf_pkg::COV_RESET;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == imukf_pkg::REG_PROCESS_NOISE) begin
        q_noise_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == imukf_pkg::REG_MEASUREMENT_NOISE) begin
        r_noise_q <= cfg_data_i;
      end
      if (fin_go) begin
        have_prev_q <= 1'b1;
        if (!first_q) begin
          cov_q <= acc_p_q[imukf_pkg::COV_W+15:16];
        end
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Round ties up, add to the previous sample, saturate to 16 bits; the first sample passes through
  always_comb begin
    logic signed [imukf_pkg::PROD_W:0] rnd;
    logic signed [18:0]                corr;
    logic signed [19:0]                sum;
    for (int k = 0; k < NAX; k++) begin
      rnd  = {acc_q[k][imukf_pkg::PROD_W-1], acc_q[k]} + 35'sd32768;
      corr = rnd[imukf_pkg::PROD_W:16];
      sum  = {{4{prev_q[k][imukf_pkg::AXIS_W-1]}}, prev_q[k]}
             + {corr[18], corr};
      if (first_q) begin
        res[k] = z_q[k];
      end else if (sum > 20'sd32767) begin
        res[k] = 16'h7FFF;
      end else if (sum < -20'sd32768) begin
        res[k] = 16'h8000;
      end else begin
        res[k] = sum[imukf_pkg::AXIS_W-1:0];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    logic signed [imukf_pkg::DIFF_W-1:0] d;
    if (s_acc) begin
      first_q    <= !have_prev_q;
      pp_q       <= pp;
      den_zero_q <= (den == '0);
      for (int k = 0; k < NAX; k++) begin
        z_q[k] <= z_in[k];
        d = {z_in[k][imukf_pkg::AXIS_W-1], z_in[k]}
            - {prev_q[k][imukf_pkg::AXIS_W-1], prev_q[k]};
        mcand_q[k] <= {{(imukf_pkg::PROD_W-imukf_pkg::DIFF_W){d[imukf_pkg::DIFF_W-1]}}, d};
      end
    end
    // Load multipliers once the gain is known
    if (state_q == ST_MSET) begin
      mplr_g_q  <= gain;
      mplr_c_q  <= imukf_pkg::FRAC_ONE - gain;
      mcand_p_q <= {{(imukf_pkg::CPROD_W-imukf_pkg::COV_W){1'b0}}, pp_q};
      acc_p_q   <= '0;
      cnt_q     <= imukf_pkg::SERIAL_STEPS;
      for (int k = 0; k < NAX; k++) begin
        acc_q[k] <= '0;
      end
    end
    // Shift-add: one multiplier bit per cycle for all four products
    if (state_q == ST_MUL) begin
      mplr_g_q  <= mplr_g_q >> 1;
      mplr_c_q  <= mplr_c_q >> 1;
      mcand_p_q <= mcand_p_q << 1;
      cnt_q     <= cnt_q - 1'b1;
      if (mplr_c_q[0]) begin
        acc_p_q <= acc_p_q + mcand_p_q;
      end
      for (int k = 0; k < NAX; k++) begin
        mcand_q[k] <= mcand_q[k] <<< 1;
        if (mplr_g_q[0]) begin
          acc_q[k] <= acc_q[k] + mcand_q[k];
        end
      end
    end
    if (fin_go) begin
      for (int k = 0; k < NAX; k++) begin
        out_q[k]  <= res[k];
        prev_q[k] <= z_q[k];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q[2], out_q[1], out_q[0]};

endmodule
